// ===== src/dltq_pkg.sv =====
// ----------------------------------------------------------------------------
// dltq_pkg
// Shared codes and constants for the delta-list timer queue.
// ----------------------------------------------------------------------------
package dltq_pkg;

    localparam int NUM_TIMERS_DEF = 16;
    localparam int DELTA_BITS_DEF = 32;
    localparam int MAX_OUT        = 16;

    localparam logic [1:0] OP_TICK    = 2'd0;
    localparam logic [1:0] OP_START   = 2'd1;
    localparam logic [1:0] OP_DELETE  = 2'd2;
    localparam logic [1:0] OP_INVALID = 2'd3;

    localparam logic [1:0] EV_OK      = 2'd0;
    localparam logic [1:0] EV_REJECT  = 2'd1;
    localparam logic [1:0] EV_EXPIRED = 2'd2;

    typedef enum logic [2:0] {
        M_HOLD,
        M_LEFT,
        M_LEFT_SUB,
        M_LOAD,
        M_RIGHT,
        M_RIGHT_ADD,
        M_DEC
    } cell_mode_t;

endpackage

// ===== src/delta_list_timer_queue.sv =====
// ----------------------------------------------------------------------------
// delta_list_timer_queue
// Timer queue kept as a sorted delta list in a row of shifting cells.
// ----------------------------------------------------------------------------
// A request is taken when start is high and busy is low; busy stays high
// until the request is finished. Each result appears on done for one cycle
// and cannot be held off. A bad op or timer id is rejected at accept; a start
// refused for a zero period answers after the lookup, a delete after the
// unlink, and a start inserts after both: the insert walks the list one cell
// a cycle. A tick decrements the head, then pops, reads and emits each
// expiring timer; a repeating one is first reinserted by a further list walk.
// ----------------------------------------------------------------------------
module delta_list_timer_queue #(
    parameter int NUM_TIMERS = dltq_pkg::NUM_TIMERS_DEF,
    parameter int DELTA_BITS = dltq_pkg::DELTA_BITS_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [1:0]  op,
    input  logic [3:0]  timer_id,
    input  logic [31:0] period,
    input  logic        repeat_req,
    output logic        done,
    output logic [1:0]  event_res,
    output logic [3:0]  timer_id_res,
    output logic        last
);

    localparam int          ID_W      = $clog2(NUM_TIMERS);
    localparam int          DW        = DELTA_BITS;
    localparam logic [31:0] DELTA_MAX = 32'hFFFF_FFFF >> (32 - DELTA_BITS);

    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_LOOKUP = 3'd1;
    localparam logic [2:0] S_UNLINK = 3'd2;
    localparam logic [2:0] S_INSERT = 3'd3;
    localparam logic [2:0] S_TICK   = 3'd4;
    localparam logic [2:0] S_POP    = 3'd5;
    localparam logic [2:0] S_POPRD  = 3'd6;
    localparam logic [2:0] S_EMIT   = 3'd7;

    localparam logic [1:0] C_NONE = 2'd0;
    localparam logic [1:0] C_INS  = 2'd1;
    localparam logic [1:0] C_DEL  = 2'd2;
    localparam logic [1:0] C_DEC  = 2'd3;

    logic [2:0]            state_reg, state_next;
    logic [1:0]            op_reg, op_next;
    logic [ID_W-1:0]       t_reg, t_next;
    logic [3:0]            tid_reg, tid_next;
    logic                  rep_reg, rep_next;
    logic [DW-1:0]         d_reg, d_next;
    logic [ID_W-1:0]       k_reg, k_next;
    logic [4:0]            n_reg, n_next;
    logic                  tick_reg, tick_next;
    logic                  done_reg, done_next;
    logic [1:0]            ev_reg, ev_next;
    logic [3:0]            res_id_reg, res_id_next;
    logic                  last_reg, last_next;
    logic [NUM_TIMERS-1:0] svld_reg, svld_next;
    logic                  svld_rd_reg;

    logic                  cv  [NUM_TIMERS];
    logic [ID_W-1:0]       cid [NUM_TIMERS];
    logic [DW-1:0]         cd  [NUM_TIMERS];
    dltq_pkg::cell_mode_t  cmode [NUM_TIMERS];

    logic [1:0]            cmd;
    logic [ID_W-1:0]       cmd_pos;
    logic [ID_W-1:0]       ld_id;
    logic [DW-1:0]         ld_delta;

    logic                  ram_we;
    logic [ID_W-1:0]       ram_raddr;
    logic [DW:0]           ram_rdata;
    logic [ID_W-1:0]       id_idx;

    logic                  match_any;
    logic [ID_W-1:0]       match_pos;
    logic [DW-1:0]         stored_per;
    logic [DW-1:0]         eff;
    logic                  head_zero;

    assign id_idx = ID_W'(timer_id);

    dltq_ram #(
        .WIDTH (DW + 1),
        .DEPTH (NUM_TIMERS)
    ) u_period_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (t_reg),
        .wdata ({rep_reg, eff}),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    genvar gi;
    generate
        for (gi = 0; gi < NUM_TIMERS; gi++)
        begin : g_cell
            logic            lv, rv;
            logic [ID_W-1:0] lid, rid;
            logic [DW-1:0]   ld, rd;

            if (gi == 0)
            begin : g_first
                assign lv  = 1'b0;
                assign lid = '0;
                assign ld  = '0;
            end
            else
            begin : g_mid_l
                assign lv  = cv[gi-1];
                assign lid = cid[gi-1];
                assign ld  = cd[gi-1];
            end

            if (gi == NUM_TIMERS - 1)
            begin : g_final
                assign rv  = 1'b0;
                assign rid = '0;
                assign rd  = '0;
            end
            else
            begin : g_mid_r
                assign rv  = cv[gi+1];
                assign rid = cid[gi+1];
                assign rd  = cd[gi+1];
            end

            always_comb
            begin
                cmode[gi] = dltq_pkg::M_HOLD;
                unique case (cmd)
                    C_INS:
                    begin
                        if (ID_W'(gi) == cmd_pos)
                        begin
                            cmode[gi] = dltq_pkg::M_LOAD;
                        end
                        else if ((ID_W + 1)'(gi) == {1'b0, cmd_pos} + 1'b1)
                        begin
                            cmode[gi] = dltq_pkg::M_LEFT_SUB;
                        end
                        else if (ID_W'(gi) > cmd_pos)
                        begin
                            cmode[gi] = dltq_pkg::M_LEFT;
                        end
                    end
                    C_DEL:
                    begin
                        if (ID_W'(gi) == cmd_pos)
                        begin
                            cmode[gi] = dltq_pkg::M_RIGHT_ADD;
                        end
                        else if (ID_W'(gi) > cmd_pos)
                        begin
                            cmode[gi] = dltq_pkg::M_RIGHT;
                        end
                    end
                    C_DEC:
                    begin
                        if (gi == 0)
                        begin
                            cmode[gi] = dltq_pkg::M_DEC;
                        end
                    end
                    default:
                    begin
                    end
                endcase
            end

            dltq_cell #(
                .ID_W (ID_W),
                .DW   (DW)
            ) u_cell (
                .clk         (clk),
                .rst_n       (rst_n),
                .mode        (cmode[gi]),
                .ld_id       (ld_id),
                .ld_delta    (ld_delta),
                .left_valid  (lv),
                .left_id     (lid),
                .left_delta  (ld),
                .right_valid (rv),
                .right_id    (rid),
                .right_delta (rd),
                .valid       (cv[gi]),
                .id          (cid[gi]),
                .delta       (cd[gi])
            );
        end
    endgenerate

    always_comb
    begin
        match_any = 1'b0;
        match_pos = '0;
        for (int i = 0; i < NUM_TIMERS; i++)
        begin
            if (cv[i] && cid[i] == t_reg)
            begin
                match_any = 1'b1;
                match_pos = match_pos | ID_W'(i);
            end
        end
    end

    // d_reg holds the saturated request period captured at accept
    assign stored_per = svld_rd_reg ? ram_rdata[DW-1:0] : '0;
    assign eff = (d_reg == '0) ? stored_per : d_reg;
    assign head_zero = cv[0] && (cd[0] == '0);

    always_comb
    begin
        state_next  = state_reg;
        op_next     = op_reg;
        t_next      = t_reg;
        tid_next    = tid_reg;
        rep_next    = rep_reg;
        d_next      = d_reg;
        k_next      = k_reg;
        n_next      = n_reg;
        tick_next   = tick_reg;
        done_next   = 1'b0;
        ev_next     = ev_reg;
        res_id_next = res_id_reg;
        last_next   = last_reg;
        svld_next   = svld_reg;
        cmd         = C_NONE;
        cmd_pos     = '0;
        ld_id       = t_reg;
        ld_delta    = d_reg;
        ram_we      = 1'b0;
        ram_raddr   = id_idx;

        unique case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    op_next  = op;
                    t_next   = id_idx;
                    tid_next = timer_id;
                    rep_next = repeat_req;
                    d_next   = (period > DELTA_MAX) ? DW'(DELTA_MAX) : DW'(period);
                    if (op == dltq_pkg::OP_TICK)
                    begin
                        state_next = S_TICK;
                    end
                    else if (op == dltq_pkg::OP_INVALID || 32'(timer_id) >= NUM_TIMERS)
                    begin
                        done_next   = 1'b1;
                        ev_next     = dltq_pkg::EV_REJECT;
                        res_id_next = timer_id;
                        last_next   = 1'b1;
                    end
                    else if (op == dltq_pkg::OP_START)
                    begin
                        state_next = S_LOOKUP;
                    end
                    else
                    begin
                        state_next = S_UNLINK;
                    end
                end
            end
            S_LOOKUP:
            begin
                if (eff == '0)
                begin
                    done_next   = 1'b1;
                    ev_next     = dltq_pkg::EV_REJECT;
                    res_id_next = tid_reg;
                    last_next   = 1'b1;
                    state_next  = S_IDLE;
                end
                else
                begin
                    ram_we           = 1'b1;
                    svld_next[t_reg] = 1'b1;
                    d_next           = eff;
                    state_next       = S_UNLINK;
                end
            end
            S_UNLINK:
            begin
                if (match_any)
                begin
                    cmd     = C_DEL;
                    cmd_pos = match_pos;
                end
                if (op_reg == dltq_pkg::OP_START)
                begin
                    k_next     = '0;
                    tick_next  = 1'b0;
                    state_next = S_INSERT;
                end
                else
                begin
                    done_next   = 1'b1;
                    ev_next     = dltq_pkg::EV_OK;
                    res_id_next = tid_reg;
                    last_next   = 1'b1;
                    state_next  = S_IDLE;
                end
            end
            S_INSERT:
            begin
                if (!cv[k_reg] || d_reg < cd[k_reg])
                begin
                    cmd     = C_INS;
                    cmd_pos = k_reg;
                    if (tick_reg)
                    begin
                        state_next = S_EMIT;
                    end
                    else
                    begin
                        done_next   = 1'b1;
                        ev_next     = dltq_pkg::EV_OK;
                        res_id_next = tid_reg;
                        last_next   = 1'b1;
                        state_next  = S_IDLE;
                    end
                end
                else
                begin
                    d_next = d_reg - cd[k_reg];
                    k_next = k_reg + 1'b1;
                end
            end
            S_TICK:
            begin
                cmd        = C_DEC;
                n_next     = '0;
                state_next = S_POP;
            end
            S_POP:
            begin
                ram_raddr = cid[0];
                if (n_reg < 5'(dltq_pkg::MAX_OUT) && head_zero)
                begin
                    cmd        = C_DEL;
                    cmd_pos    = '0;
                    t_next     = cid[0];
                    state_next = S_POPRD;
                end
                else
                begin
                    state_next = S_IDLE;
                end
            end
            S_POPRD:
            begin
                if (ram_rdata[DW])
                begin
                    d_next     = ram_rdata[DW-1:0];
                    k_next     = '0;
                    tick_next  = 1'b1;
                    state_next = S_INSERT;
                end
                else
                begin
                    state_next = S_EMIT;
                end
            end
            S_EMIT:
            begin
                done_next   = 1'b1;
                ev_next     = dltq_pkg::EV_EXPIRED;
                res_id_next = 4'(t_reg);
                last_next   = (n_reg == 5'(dltq_pkg::MAX_OUT - 1)) || !head_zero;
                n_next      = n_reg + 1'b1;
                state_next  = last_next ? S_IDLE : S_POP;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            done_reg  <= 1'b0;
            svld_reg  <= '0;
        end
        else
        begin
            state_reg <= state_next;
            done_reg  <= done_next;
            svld_reg  <= svld_next;
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg      <= op_next;
        t_reg       <= t_next;
        tid_reg     <= tid_next;
        rep_reg     <= rep_next;
        d_reg       <= d_next;
        k_reg       <= k_next;
        n_reg       <= n_next;
        tick_reg    <= tick_next;
        ev_reg      <= ev_next;
        res_id_reg  <= res_id_next;
        last_reg    <= last_next;
        svld_rd_reg <= svld_reg[ram_raddr];
    end

    assign busy         = (state_reg != S_IDLE);
    assign done         = done_reg;
    assign event_res    = ev_reg;
    assign timer_id_res = res_id_reg;
    assign last         = last_reg;

endmodule

// ===== src/dltq_ram.sv =====
// ----------------------------------------------------------------------------
// dltq_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module dltq_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        rdata_reg <= mem_reg[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// ===== src/dltq_cell.sv =====
// ----------------------------------------------------------------------------
// dltq_cell
// One list position: valid flag, timer slot and delta to the entry ahead.
// ----------------------------------------------------------------------------
module dltq_cell #(
    parameter int ID_W = 4,
    parameter int DW   = 32
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  dltq_pkg::cell_mode_t  mode,
    input  logic [ID_W-1:0]       ld_id,
    input  logic [DW-1:0]         ld_delta,
    input  logic                  left_valid,
    input  logic [ID_W-1:0]       left_id,
    input  logic [DW-1:0]         left_delta,
    input  logic                  right_valid,
    input  logic [ID_W-1:0]       right_id,
    input  logic [DW-1:0]         right_delta,
    output logic                  valid,
    output logic [ID_W-1:0]       id,
    output logic [DW-1:0]         delta
);

    logic            valid_reg, valid_next;
    logic [ID_W-1:0] id_reg, id_next;
    logic [DW-1:0]   delta_reg, delta_next;
    logic [DW:0]     sum;

    assign sum = {1'b0, right_delta} + {1'b0, delta_reg};

    always_comb
    begin
        valid_next = valid_reg;
        id_next    = id_reg;
        delta_next = delta_reg;
        unique case (mode)
            dltq_pkg::M_HOLD:
            begin
            end
            dltq_pkg::M_LEFT:
            begin
                valid_next = left_valid;
                id_next    = left_id;
                delta_next = left_delta;
            end
            dltq_pkg::M_LEFT_SUB:
            begin
                valid_next = left_valid;
                id_next    = left_id;
                delta_next = left_delta - ld_delta;
            end
            dltq_pkg::M_LOAD:
            begin
                valid_next = 1'b1;
                id_next    = ld_id;
                delta_next = ld_delta;
            end
            dltq_pkg::M_RIGHT:
            begin
                valid_next = right_valid;
                id_next    = right_id;
                delta_next = right_delta;
            end
            dltq_pkg::M_RIGHT_ADD:
            begin
                valid_next = right_valid;
                id_next    = right_id;
                delta_next = sum[DW] ? {DW{1'b1}} : sum[DW-1:0];
            end
            dltq_pkg::M_DEC:
            begin
                if (valid_reg && delta_reg != '0)
                begin
                    delta_next = delta_reg - 1'b1;
                end
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        id_reg    <= id_next;
        delta_reg <= delta_next;
    end

    assign valid = valid_reg;
    assign id    = id_reg;
    assign delta = delta_reg;

endmodule

// ===== dv/delta_list_timer_queue_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// delta_list_timer_queue_checker
// Watches request and result transfers of the timer queue, keeps its own
// copy of the delta list, works out the expected events and compares them.
// ----------------------------------------------------------------------------
module delta_list_timer_queue_checker
    import dltq_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    input  logic        busy,
    input  logic [1:0]  op,
    input  logic [3:0]  timer_id,
    input  logic [31:0] period,
    input  logic        repeat_req,
    input  logic        done,
    input  logic [1:0]  event_res,
    input  logic [3:0]  timer_id_res,
    input  logic        last,
    output int          errors,
    output int          pending
);

    localparam int NT  = 16;
    localparam int NIL = NT;

    typedef struct packed {
        logic [1:0] ev;
        logic [3:0] id;
        logic       lst;
    } timer_event_t;

    timer_event_t event_q[$];

    logic [31:0] q_delta  [NT];
    int          q_next   [NT];
    logic        q_linked [NT];
    logic        q_repeat [NT];
    logic [31:0] q_period [NT];
    int          q_head;

    assign pending = event_q.size();

    function automatic logic [31:0] add_sat(logic [31:0] a, logic [31:0] b);
        logic [32:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[32] ? 32'hFFFF_FFFF : s[31:0];
    endfunction

    task automatic unlink_timer(int t);
        int prv;
        int cur;
        int k;
        prv = NIL;
        cur = q_head;
        k = 0;
        if (!q_linked[t])
            return;
        while (cur < NT && cur != t && k < NT)
        begin
            prv = cur;
            cur = q_next[cur];
            k++;
        end
        if (cur == t)
        begin
            if (q_next[t] < NT)
                q_delta[q_next[t]] = add_sat(q_delta[q_next[t]], q_delta[t]);
            if (prv == NIL)
                q_head = q_next[t];
            else
                q_next[prv] = q_next[t];
        end
        q_linked[t] = 0;
        q_next[t] = NIL;
        q_delta[t] = 0;
    endtask

    task automatic place_timer(int t);
        logic [31:0] d;
        int prv;
        int cur;
        int k;
        d = q_period[t];
        prv = NIL;
        cur = q_head;
        k = 0;
        while (cur < NT && k < NT)
        begin
            if (d < q_delta[cur])
            begin
                q_delta[cur] -= d;
                break;
            end
            d -= q_delta[cur];
            prv = cur;
            cur = q_next[cur];
            k++;
        end
        q_next[t] = (cur < NT) ? cur : NIL;
        if (prv == NIL)
            q_head = t;
        else
            q_next[prv] = t;
        q_delta[t] = d;
        q_linked[t] = 1;
    endtask

    task automatic predict_request(logic [1:0] o, logic [3:0] id, logic [31:0] per, logic rep);
        int fired[$];
        int t;
        logic [31:0] eff;
        if (o == OP_TICK)
        begin
            if (q_head < NT && q_delta[q_head] > 0)
                q_delta[q_head]--;
            while (fired.size() < MAX_OUT && q_head < NT && q_delta[q_head] == 0)
            begin
                t = q_head;
                q_head = q_next[t];
                q_next[t] = NIL;
                q_linked[t] = 0;
                fired.push_back(t);
            end
            foreach (fired[i])
            begin
                if (q_repeat[fired[i]])
                    place_timer(fired[i]);
                event_q.push_back({EV_EXPIRED, 4'(fired[i]), i == fired.size() - 1});
            end
        end
        else if (o == OP_START)
        begin
            eff = (per != 0) ? per : q_period[id];
            if (eff == 0)
                event_q.push_back({EV_REJECT, id, 1'b1});
            else
            begin
                q_period[id] = eff;
                q_repeat[id] = rep;
                unlink_timer(id);
                place_timer(id);
                event_q.push_back({EV_OK, id, 1'b1});
            end
        end
        else if (o == OP_DELETE)
        begin
            unlink_timer(id);
            event_q.push_back({EV_OK, id, 1'b1});
        end
        else
            event_q.push_back({EV_REJECT, id, 1'b1});
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        timer_event_t exp_ev;
        if (!rst_n)
        begin
            errors <= 0;
            event_q.delete();
            for (int i = 0; i < NT; i++)
            begin
                q_delta[i] = 0;
                q_next[i] = NIL;
                q_linked[i] = 0;
                q_repeat[i] = 0;
                q_period[i] = 0;
            end
            q_head = NIL;
        end
        else
        begin
            // result before request: a result never belongs to a request in the same edge
            if (done)
            begin
                if (event_q.size() == 0)
                begin
                    $display("%0t: unexpected result ev=%0d id=%0d last=%0d",
                             $time, event_res, timer_id_res, last);
                    errors <= errors + 1;
                end
                else
                begin
                    exp_ev = event_q.pop_front();
                    if (exp_ev !== {event_res, timer_id_res, last})
                    begin
                        $display("%0t: expected ev/id/last %0d/%0d/%0d, got %0d/%0d/%0d",
                                 $time, exp_ev.ev, exp_ev.id, exp_ev.lst,
                                 event_res, timer_id_res, last);
                        errors <= errors + 1;
                    end
                end
            end
            if (start && !busy)
                predict_request(op, timer_id, period, repeat_req);
        end
    end

endmodule

// ===== dv/delta_list_timer_queue_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// delta_list_timer_queue_tb
// Drives directed and random timer requests and ticks through several
// idling phases; the checker reports mismatches, this module the verdict.
// ----------------------------------------------------------------------------
module delta_list_timer_queue_tb;
    import dltq_pkg::*;

    logic        clk;
    logic        rst_n;
    logic        start;
    logic        busy;
    logic [1:0]  op;
    logic [3:0]  timer_id;
    logic [31:0] period;
    logic        repeat_req;
    logic        done;
    logic [1:0]  event_res;
    logic [3:0]  timer_id_res;
    logic        last;
    int          errors;
    int          pending;
    int          idle_pct;
    int          stall_cycles;

    delta_list_timer_queue uut (.*);

    delta_list_timer_queue_checker chk (.*);

    always
    begin
        clk = 1'b0;
        #2;
        clk = 1'b1;
        #2;
    end

    always @(posedge clk)
    begin
        if (!rst_n || (start && !busy) || done)
            stall_cycles <= 0;
        else
            stall_cycles <= stall_cycles + 1;
        if (stall_cycles > 5000)
        begin
            $display("FAILURE");
            $finish;
        end
    end

    // start stays high between back-to-back requests; it drops only while idling
    task automatic send_request(logic [1:0] o, logic [3:0] id, logic [31:0] per, logic rep);
        while ($urandom_range(99) < idle_pct)
        begin
            start <= 1'b0;
            @(posedge clk);
        end
        start      <= 1'b1;
        op         <= o;
        timer_id   <= id;
        period     <= per;
        repeat_req <= rep;
        @(posedge clk);
        while (busy)
            @(posedge clk);
    endtask

    function automatic logic [31:0] rand_period();
        case ($urandom_range(9))
            0:       return 32'd0;
            1:       return $urandom();
            2:       return 32'hFFFF_FFFF;
            default: return $urandom_range(1, 12);
        endcase
    endfunction

    task automatic random_request();
        int r;
        r = $urandom_range(99);
        if (r < 50)
            send_request(OP_TICK, 4'($urandom()), $urandom(), 1'($urandom()));
        else if (r < 82)
            send_request(OP_START, 4'($urandom()), rand_period(), 1'($urandom()));
        else if (r < 97)
            send_request(OP_DELETE, 4'($urandom()), $urandom(), 1'($urandom()));
        else
            send_request(OP_INVALID, 4'($urandom()), $urandom(), 1'($urandom()));
    endtask

    initial
    begin
        rst_n      = 1'b0;
        start      = 1'b0;
        op         = OP_TICK;
        timer_id   = '0;
        period     = '0;
        repeat_req = 1'b0;
        idle_pct   = 0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        send_request(OP_TICK, 4'd0, 32'd0, 1'b0);
        send_request(OP_START, 4'd3, 32'd0, 1'b0);
        send_request(OP_START, 4'd0, 32'd2, 1'b1);
        send_request(OP_START, 4'd15, 32'd2, 1'b0);
        send_request(OP_START, 4'd7, 32'hFFFF_FFFF, 1'b0);
        send_request(OP_START, 4'd5, 32'd1, 1'b1);
        send_request(OP_START, 4'd5, 32'd0, 1'b1);
        send_request(OP_DELETE, 4'd9, 32'd0, 1'b0);
        send_request(OP_INVALID, 4'd11, 32'hA5A5_5A5A, 1'b1);
        for (int i = 0; i < 3; i++)
            send_request(OP_TICK, 4'd0, 32'd0, 1'b0);
        send_request(OP_DELETE, 4'd7, 32'd0, 1'b0);
        for (int i = 0; i < 16; i++)
            send_request(OP_START, 4'(i), 32'd1, 1'b1);
        send_request(OP_TICK, 4'd0, 32'd0, 1'b0);
        send_request(OP_TICK, 4'd0, 32'd0, 1'b0);

        for (int ph = 0; ph < 4; ph++)
        begin
            idle_pct = (ph == 1) ? 46 : (ph == 3) ? 7 : 0;
            for (int i = 0; i < 17; i++)
                random_request();
            if (ph == 1)
            begin
                start <= 1'b0;
                @(posedge clk);
                while (pending != 0)
                    @(posedge clk);
            end
        end

        start <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (600) @(posedge clk);
        if (errors == 0 && pending == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule
